// ===== design/gsbp_pkg.sv =====
// Shared types, constants and action codes of the gshare branch predictor.
package gsbp_pkg;

   // Table geometry
   localparam int HISTORY_BITS = 12;
   localparam int COUNTER_BITS = 2;
   localparam int TABLE_DEPTH  = 1 << HISTORY_BITS;

   // Fixed field widths of the channels
   localparam int ACTION_W = 3;
   localparam int PC_W     = 48;
   localparam int SNAP_W   = 12;
   localparam int SHIFT_W  = 3;

   localparam logic [SHIFT_W-1:0] INST_SHIFT_RESET = SHIFT_W'(2);

   typedef logic [HISTORY_BITS-1:0] hist_type;
   typedef logic [HISTORY_BITS-1:0] idx_type;
   typedef logic [COUNTER_BITS-1:0] ctr_type;

   localparam ctr_type CTR_MAX = '1;

   // Action codes carried in the request word
   typedef enum logic [ACTION_W-1:0] {
      ACT_LOOKUP = 3'd0,
      ACT_UNCOND = 3'd1,
      ACT_BTB_MISS = 3'd2,
      ACT_UPDATE = 3'd3,
      ACT_SQUASH = 3'd4
   } action_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [PC_W-1:0]     pc;
      logic [SNAP_W-1:0]   saved_history;
      logic                has_history;
      logic                taken;
      logic                mispredicted;
   } req_word_type;

   typedef struct packed {
      logic              prediction;
      logic [SNAP_W-1:0] history_snapshot;
   } rsp_word_type;

endpackage

// ===== design/gshare_speculative_branch_predictor.sv =====
// Top level of the gshare predictor: shift register, result register and core.
//
// Request words (req_valid, req_stall, req_word) carry lookups, unconditional
// branches, BTB misses, resolve updates and squashes. Lookups and unconditional
// branches return one response word (rsp_valid, rsp_stall, rsp_word) with the
// prediction and the history as it stood before; the other actions return none.
// A word is taken at a clock edge with valid high and stall low.
// One word per cycle is taken while req_stall is low: the counter table is read
// at acceptance, the stage forms the prediction and new history, and a counter
// update writes back from the stage, forwarded to a following word that hits
// the same entry. The response passes from the stage register into the response
// register, which drives rsp_valid.
// While the response register is full and rsp_stall is high, one further lookup
// or unconditional branch may enter and wait; behind it req_stall stays high
// until the response is taken. Words that return nothing keep flowing.
// After reset the history is zero, inst_shift is 2, and a sweep clears all 4096
// counter entries while req_stall is high. The user must write inst_shift
// (csr_write_enable, csr_write_data) only while idle; the block does not check.
module gshare_speculative_branch_predictor import gsbp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_word_type       req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_word_type       rsp_word,
   input  logic               csr_write_enable,
   input  logic [SHIFT_W-1:0] csr_write_data
);

   logic [SHIFT_W-1:0] inst_shift_ff, inst_shift_in;
   logic               out_valid_ff, out_valid_in;
   rsp_word_type       out_word_ff, out_word_in;

   logic         res_free, res_valid;
   rsp_word_type res_word;

   gsbp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .inst_shift(inst_shift_ff),
      .res_free  (res_free),
      .res_valid (res_valid),
      .res_word  (res_word)
   );

   // Shift register
   assign inst_shift_in = csr_write_enable ? csr_write_data : inst_shift_ff;

   // Response register
   assign res_free = !out_valid_ff || !rsp_stall;
   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (res_valid && res_free) begin
         out_valid_in = 1'b1;
         out_word_in  = res_word;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inst_shift_ff <= INST_SHIFT_RESET;
         out_valid_ff  <= 1'b0;
      end else begin
         inst_shift_ff <= inst_shift_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

// ===== design/gsbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gsbp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Read returns the old contents when both ports hit the same entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

endmodule

// ===== design/gsbp_core.sv =====
// Predictor core: table access, work stage, history register and clearing sweep.
module gsbp_core import gsbp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_word_type       req_word,
   input  logic [SHIFT_W-1:0] inst_shift,
   input  logic               res_free,
   output logic               res_valid,
   output rsp_word_type       res_word
);

   logic         stage_valid_ff, stage_valid_in;
   req_word_type stage_word_ff, stage_word_in;
   idx_type      stage_addr_ff, stage_addr_in;
   logic         fwd_hit_ff, fwd_hit_in;
   ctr_type      fwd_data_ff, fwd_data_in;
   hist_type     hist_ff, hist_in;
   logic         clear_ff, clear_in;
   idx_type      clear_addr_ff, clear_addr_in;

   logic     accept;
   logic     stage_lookup, stage_uncond, stage_has_result, stage_go;
   logic     upd_wr;
   ctr_type  ram_rd_data, ctr_cur, ctr_new;
   logic     pred;
   hist_type stage_snap, req_snap, rd_hist;
   idx_type  req_hashed, rd_addr;
   logic     ram_wr_en;
   idx_type  ram_wr_addr;
   ctr_type  ram_wr_data;

   // Counter table
   gsbp_ram #(
      .WIDTH(COUNTER_BITS),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .rd_en  (accept),
      .rd_addr(rd_addr),
      .rd_data(ram_rd_data),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data)
   );

   // Stage decode and handshake
   assign stage_lookup     = (stage_word_ff.action == ACT_LOOKUP);
   assign stage_uncond     = (stage_word_ff.action == ACT_UNCOND);
   assign stage_has_result = stage_lookup || stage_uncond;
   assign stage_go         = stage_valid_ff && (!stage_has_result || res_free);
   assign req_stall        = clear_ff || (stage_valid_ff && !stage_go);
   assign accept           = req_valid && !req_stall;

   // Counter value, with the write of the previous word forwarded
   assign ctr_cur = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
   assign pred    = ctr_cur[COUNTER_BITS-1];

   // Saturating train
   always_comb begin
      ctr_new = ctr_cur;
      if (stage_word_ff.taken) begin
         if (ctr_cur != CTR_MAX) begin
            ctr_new = ctr_cur + COUNTER_BITS'(1);
         end
      end else begin
         if (ctr_cur != '0) begin
            ctr_new = ctr_cur - COUNTER_BITS'(1);
         end
      end
   end

   assign upd_wr = stage_go && (stage_word_ff.action == ACT_UPDATE) &&
                   stage_word_ff.has_history;

   // Write port: clearing sweep or a counter update
   assign ram_wr_en   = clear_ff || upd_wr;
   assign ram_wr_addr = clear_ff ? clear_addr_ff : stage_addr_ff;
   assign ram_wr_data = clear_ff ? '0 : ctr_new;

   // Result of the word in the stage
   assign res_valid                 = stage_valid_ff && stage_has_result;
   assign res_word.prediction       = stage_uncond ? 1'b1 : pred;
   assign res_word.history_snapshot = SNAP_W'(hist_ff);

   // History after the word in the stage
   assign stage_snap = hist_type'(stage_word_ff.saved_history);
   always_comb begin
      hist_in = hist_ff;
      if (stage_go) begin
         unique case (stage_word_ff.action)
            ACT_LOOKUP:   hist_in = hist_type'({hist_ff, pred});
            ACT_UNCOND:   hist_in = hist_type'({hist_ff, 1'b1});
            ACT_BTB_MISS: hist_in = hist_ff & ~hist_type'(1);
            ACT_UPDATE: begin
               if (stage_word_ff.has_history && stage_word_ff.mispredicted) begin
                  hist_in = hist_type'({stage_snap, stage_word_ff.taken});
               end
            end
            ACT_SQUASH:   hist_in = stage_snap;
            default:      hist_in = hist_ff;
         endcase
      end
   end

   // Table index for the incoming word
   assign req_hashed = idx_type'(req_word.pc >> inst_shift);
   assign req_snap   = hist_type'(req_word.saved_history);
   assign rd_hist    = (req_word.action == ACT_UPDATE) ? req_snap : hist_in;
   assign rd_addr    = req_hashed ^ rd_hist;

   // Stage and forwarding registers
   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_word_in  = stage_word_ff;
      stage_addr_in  = stage_addr_ff;
      fwd_hit_in     = fwd_hit_ff;
      fwd_data_in    = fwd_data_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
         stage_word_in  = req_word;
         stage_addr_in  = rd_addr;
         fwd_hit_in     = upd_wr && (rd_addr == stage_addr_ff);
         fwd_data_in    = ctr_new;
      end else if (stage_go) begin
         stage_valid_in = 1'b0;
      end
   end

   // Clearing sweep after reset, one entry a cycle
   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + idx_type'(1);
         if (clear_addr_ff == '1) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         fwd_hit_ff     <= 1'b0;
         hist_ff        <= '0;
         clear_ff       <= 1'b1;
         clear_addr_ff  <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         fwd_hit_ff     <= fwd_hit_in;
         hist_ff        <= hist_in;
         clear_ff       <= clear_in;
         clear_addr_ff  <= clear_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_word_ff <= stage_word_in;
      stage_addr_ff <= stage_addr_in;
      fwd_data_ff   <= fwd_data_in;
   end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the gshare speculative branch predictor.
module testbench import gsbp_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam ctr_type CTR_HALF = ctr_type'((1 << (COUNTER_BITS - 1)) - 1);
   localparam logic [PC_W-1:0]   PC_ALL   = '1;
   localparam logic [SNAP_W-1:0] SNAP_ALL = '1;
   localparam int POOL_SIZE   = 16;
   localparam int MAX_PENDING = 32;
   localparam int SETTLE      = 4;
   localparam int DRAIN_LIMIT = 5000;

   // A branch that has been looked up and not yet resolved
   typedef struct {
      logic [PC_W-1:0] pc;
      hist_type        snap;
      logic            pred;
   } branch_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_word_type       req_word = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_word_type       rsp_word;
   logic               csr_write_enable = 1'b0;
   logic [SHIFT_W-1:0] csr_write_data = '0;

   // Predictor state
   logic [SHIFT_W-1:0] shift_amount = INST_SHIFT_RESET;
   hist_type           spec_history = '0;
   ctr_type            counter_table [TABLE_DEPTH];
   rsp_word_type       expected_rsp [$];

   branch_type         in_flight [$];
   logic [PC_W-1:0]    pc_pool [POOL_SIZE];
   bit                 traffic_gaps = 1'b1;
   int                 errors = 0;
   rsp_word_type       want;

   gshare_speculative_branch_predictor dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Run ends here if traffic stops
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_error(string msg);
      errors++;
      if (errors <= 10) $display("ERROR at %0t: %s", $time, msg);
   endtask

   // Gap length in cycles: mostly none or short, now and then long
   function automatic int idle_gap();
      int r;
      if (!traffic_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [PC_W-1:0] random_pc();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[PC_W-1:0];
   endfunction

   function automatic req_word_type make_word(logic [ACTION_W-1:0] act, logic [PC_W-1:0] pc,
                                              logic [SNAP_W-1:0] snap, logic hh, logic tk,
                                              logic mp);
      req_word_type w;
      w.action        = act;
      w.pc            = pc;
      w.saved_history = snap;
      w.has_history   = hh;
      w.taken         = tk;
      w.mispredicted  = mp;
      return w;
   endfunction

   function automatic idx_type hash_index(logic [PC_W-1:0] pc, hist_type h);
      logic [PC_W-1:0] shifted;
      shifted = pc >> shift_amount;
      return shifted[HISTORY_BITS-1:0] ^ h;
   endfunction

   // Apply one accepted request word to the predictor and queue its response
   task automatic advance_predictor(req_word_type w);
      idx_type      idx;
      hist_type     snap;
      rsp_word_type r;
      snap = hist_type'(w.saved_history);
      case (w.action)
         ACT_LOOKUP: begin
            idx = hash_index(w.pc, spec_history);
            r.prediction = counter_table[idx] > CTR_HALF;
            r.history_snapshot = SNAP_W'(spec_history);
            expected_rsp.push_back(r);
            spec_history = {spec_history[HISTORY_BITS-2:0], r.prediction};
         end
         ACT_UNCOND: begin
            r.prediction = 1'b1;
            r.history_snapshot = SNAP_W'(spec_history);
            expected_rsp.push_back(r);
            spec_history = {spec_history[HISTORY_BITS-2:0], 1'b1};
         end
         ACT_BTB_MISS: spec_history[0] = 1'b0;
         ACT_UPDATE: begin
            if (w.has_history) begin
               idx = hash_index(w.pc, snap);
               if (w.taken && counter_table[idx] != CTR_MAX)
                  counter_table[idx] = counter_table[idx] + 1'b1;
               else if (!w.taken && counter_table[idx] != '0)
                  counter_table[idx] = counter_table[idx] - 1'b1;
               if (w.mispredicted) spec_history = {snap[HISTORY_BITS-2:0], w.taken};
            end
         end
         ACT_SQUASH: spec_history = snap;
         default: ;
      endcase
   endtask

   // Send one request word; called and returns at a falling edge
   task automatic send_word(req_word_type w);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      advance_predictor(w);
      @(negedge clock);
   endtask

   // Stop sending and let every outstanding word retire
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && expected_rsp.size() != 0; n++) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_inst_shift(logic [SHIFT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      shift_amount = value;
   endtask

   // Response side stall pattern
   initial begin : rsp_stall_driver
      int run;
      forever begin
         run = idle_gap();
         if (run > 0) begin
            rsp_stall <= 1'b1;
            repeat (run) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   // Compare each response word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            report_error($sformatf("unexpected response word %h", rsp_word));
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_word.prediction !== want.prediction)
               report_error($sformatf("prediction: expected %0b, got %0b",
                                      want.prediction, rsp_word.prediction));
            if (rsp_word.history_snapshot !== want.history_snapshot)
               report_error($sformatf("history_snapshot: expected %h, got %h",
                                      want.history_snapshot, rsp_word.history_snapshot));
         end
      end
   end

   // Cleared table, reset shift, history shifting and BTB miss
   task automatic test_reset_state();
      send_word(make_word(ACT_LOOKUP, '0, '0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(ACT_LOOKUP, PC_ALL, SNAP_ALL, 1'b1, 1'b1, 1'b1));
      send_word(make_word(ACT_UNCOND, PC_ALL, '0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(ACT_BTB_MISS, '0, '0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(ACT_UNCOND, '0, SNAP_ALL, 1'b1, 1'b1, 1'b1));
      send_word(make_word(ACT_UNCOND, PC_ALL, '0, 1'b0, 1'b0, 1'b0));
   endtask

   // Train one entry to both limits and past them; update without snapshot does nothing
   task automatic test_counter_saturation();
      repeat (4) send_word(make_word(ACT_UPDATE, PC_ALL, SNAP_ALL, 1'b1, 1'b1, 1'b0));
      send_word(make_word(ACT_SQUASH, '0, SNAP_ALL, 1'b0, 1'b0, 1'b0));
      send_word(make_word(ACT_LOOKUP, PC_ALL, '0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(ACT_UPDATE, PC_ALL, SNAP_ALL, 1'b0, 1'b0, 1'b1));
      repeat (4) send_word(make_word(ACT_UPDATE, PC_ALL, SNAP_ALL, 1'b1, 1'b0, 1'b0));
      send_word(make_word(ACT_SQUASH, '0, SNAP_ALL, 1'b0, 1'b0, 1'b0));
      send_word(make_word(ACT_LOOKUP, PC_ALL, '0, 1'b0, 1'b0, 1'b0));
   endtask

   // History rebuilt after a misprediction, and restored by squash
   task automatic test_history_repair();
      send_word(make_word(ACT_UPDATE, '0, '0, 1'b1, 1'b1, 1'b1));
      send_word(make_word(ACT_UNCOND, '0, '0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(ACT_UPDATE, '0, SNAP_ALL, 1'b1, 1'b0, 1'b1));
      send_word(make_word(ACT_LOOKUP, '0, '0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(ACT_SQUASH, PC_ALL, '0, 1'b1, 1'b1, 1'b1));
   endtask

   // Unused action codes leave the state alone
   task automatic test_unknown_actions();
      for (int a = ACT_SQUASH + 1; a < (1 << ACTION_W); a++)
         send_word(make_word(ACTION_W'(a), random_pc(), SNAP_W'($urandom), 1'b1,
                             1'b1, 1'b1));
      send_word(make_word(ACT_LOOKUP, random_pc(), '0, 1'b0, 1'b0, 1'b0));
   endtask

   // One random request word: mostly lookups resolved later with their snapshots
   task automatic random_word(output req_word_type w);
      logic [95:0]     bits;
      logic [PC_W-1:0] pc;
      branch_type      b;
      int              r;
      int              k;
      bits = {$urandom, $urandom, $urandom};
      w = bits[$bits(req_word_type)-1:0];
      pc = ($urandom_range(0, 3) == 0) ? random_pc() : pc_pool[$urandom_range(0, POOL_SIZE-1)];
      r = $urandom_range(0, 99);
      if (r >= 53 && r < 83 && in_flight.size() == 0) r = 0;
      if (r < 40) begin
         w.action = ACT_LOOKUP;
         w.pc = pc;
         b.pc = pc;
         b.snap = spec_history;
         b.pred = counter_table[hash_index(pc, spec_history)] > CTR_HALF;
         in_flight.push_back(b);
         if (in_flight.size() > MAX_PENDING) void'(in_flight.pop_front());
      end else if (r < 48) begin
         w.action = ACT_UNCOND;
         w.pc = pc;
      end else if (r < 53) begin
         w.action = ACT_BTB_MISS;
      end else if (r < 83) begin
         // resolve: oldest branch usually, any branch sometimes
         k = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(0, in_flight.size() - 1);
         b = in_flight[k];
         in_flight.delete(k);
         w.action = ACT_UPDATE;
         w.pc = b.pc;
         w.saved_history = SNAP_W'(b.snap);
         w.has_history = 1'b1;
         w.taken = ($urandom_range(0, 9) < 8) ? (b.pc[2] ^ b.pc[7]) : 1'($urandom);
         w.mispredicted = w.taken != b.pred;
         if (w.mispredicted) in_flight.delete();
      end else if (r < 90) begin
         w.action = ACT_SQUASH;
         if (in_flight.size() != 0)
            w.saved_history = SNAP_W'(in_flight[$urandom_range(0, in_flight.size() - 1)].snap);
         in_flight.delete();
      end
   endtask

   // Random traffic under one inst_shift setting
   task automatic test_random_traffic(logic [SHIFT_W-1:0] shift, int items, bit gaps);
      req_word_type w;
      int           n;
      drain_pipeline();
      write_inst_shift(shift);
      traffic_gaps = gaps;
      in_flight.delete();
      foreach (pc_pool[i]) pc_pool[i] = random_pc();
      n = 0;
      while (n < items) begin
         random_word(w);
         send_word(w);
         if (w.action <= ACT_SQUASH && !(w.action == ACT_UPDATE && !w.has_history)) n++;
      end
   endtask

   initial begin : stimulus
      logic [SHIFT_W-1:0] shift_plan [8];
      shift_plan = '{0, 7, 3, 5, 1, 6, 4, 2};
      foreach (counter_table[i]) counter_table[i] = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_counter_saturation();
      test_history_repair();
      test_unknown_actions();
      foreach (shift_plan[i]) test_random_traffic(shift_plan[i], 225, (i % 3) != 1);
      drain_pipeline();
      if (expected_rsp.size() != 0)
         report_error($sformatf("%0d response words never arrived", expected_rsp.size()));
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
